>>> sv/hng_pkg.sv
package hng_pkg;

  typedef struct packed {
    logic [15:0] height;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic        [9:0]  col;
    logic        [11:0] row;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [10:0] map_width;
    logic [12:0] map_height;
    logic [9:0]  region_x;
    logic [11:0] region_z;
    logic [10:0] region_w;
    logic [12:0] region_h;
  } cfg_t;

  typedef struct packed {
    logic signed [19:0] sx;
    logic signed [19:0] sz;
    logic        [9:0]  col;
    logic        [11:0] row;
    logic               last;
  } qitem_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_REGION_X   = 3'd2,
    REG_REGION_Z   = 3'd3,
    REG_REGION_W   = 3'd4,
    REG_REGION_H   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_SUM,
    B_ROOT,
    B_DSET,
    B_DIV,
    B_OUT
  } bstate_t;

  localparam int QDEPTH = 4;
  localparam logic [22:0] SY_SQ = 23'd4194304;
  localparam logic [11:0] SY = 12'd2048;

endpackage

>>> sv/heightmap_normal_generator.sv
// Heightmap normal generator.
// Heights stream in raster order on the input request channel (in_valid,
// in_stall, in_data); frame_start marks column 0, row 0 of a new map.
// Each qualifying grid point yields one unit normal (signed Q1.14) on the
// output channel (out_valid, out_stall, out_data), tagged with its column,
// row and a last flag on the final point of the region.
// Registers are written on the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high. The user must write them only while
// the block is idle; the block does not enforce this. A sample that produces
// no normal costs one cycle while in_stall is low. A normal is formed once
// the sample diagonally below-right of its point is taken; it passes the a
// and b stage registers into the queue, and the back end finishes it with
// the bit-serial square root and the shared bit-serial divider.
// A four-entry queue between front and back lets the front keep taking
// samples while the back works; in_stall rises once the queue, counting the
// normals still in the front, has no room for one more.
// While out_stall is high the finished normal holds in the output register
// and the back end holds its next result until the register frees.
// Reset restores the register defaults, clears the counters and window and
// empties the queue; the line buffers are left as they are.
module heightmap_normal_generator
  import hng_pkg::*;
#(
  parameter int MAX_WIDTH        = 1024,
  parameter int MAX_HEIGHT       = 4096,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t       cfg;
  logic       q_push, q_pop, q_empty;
  logic [2:0] q_count;
  qitem_t     push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= 11'd1024;
      cfg.map_height <= 13'd1024;
      cfg.region_x   <= 10'd0;
      cfg.region_z   <= 12'd0;
      cfg.region_w   <= 11'd1024;
      cfg.region_h   <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  cfg.map_width  <= cfg_data[10:0];
        REG_MAP_HEIGHT: cfg.map_height <= cfg_data;
        REG_REGION_X:   cfg.region_x   <= cfg_data[9:0];
        REG_REGION_Z:   cfg.region_z   <= cfg_data[11:0];
        REG_REGION_W:   cfg.region_w   <= cfg_data[10:0];
        REG_REGION_H:   cfg.region_h   <= cfg_data;
        default: ;
      endcase
    end
  end

  hng_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  hng_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  hng_back #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/hng_fifo.sv
module hng_fifo
  import hng_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  input  logic   pop,
  output qitem_t pop_item,
  output logic   empty,
  output logic [2:0] count
);

  qitem_t     mem [QDEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  assign empty    = (count == 3'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

>>> sv/hng_front.sv
module hng_front
  import hng_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  input  logic [2:0] q_count,
  output logic       q_push,
  output qitem_t     q_item
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int CXW = ((CW > 12) ? CW : 12) + 1;
  localparam int RXW = ((RW > 13) ? RW : 13) + 1;

  logic [15:0] lb0 [MAX_WIDTH];
  logic [15:0] lb1 [MAX_WIDTH];
  logic [15:0] window [9];

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  logic          a_valid, a_par, a_q, a_last;
  logic [15:0]   a_h, rd0, rd1;
  logic [9:0]    a_col;
  logic [11:0]   a_row;
  logic          b_valid, b_last;
  logic [9:0]    b_col;
  logic [11:0]   b_row;

  logic           accept;
  logic [CXW-1:0] w, mw, c, lx, rx, rsum;
  logic [RXW-1:0] h, mh, r, tz, bz, bsum;
  logic           qual, lastp;
  logic [CW-1:0]  col_next;
  logic [RW-1:0]  row_next;
  logic [3:0]     pend;

  assign pend     = {1'b0, q_count} + {3'd0, a_valid & a_q} + {3'd0, b_valid} + 4'd1;
  assign in_stall = (pend > 4'(QDEPTH));
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    mw = CXW'(cfg.map_width);
    mh = RXW'(cfg.map_height);
    w  = (mw < CXW'(3)) ? CXW'(3) : ((mw > CXW'(MAX_WIDTH)) ? CXW'(MAX_WIDTH) : mw);
    h  = (mh < RXW'(3)) ? RXW'(3) : ((mh > RXW'(MAX_HEIGHT)) ? RXW'(MAX_HEIGHT) : mh);
    if (in_data.frame_start || CXW'(col_count) >= w) begin
      c = '0;
    end else begin
      c = CXW'(col_count);
    end
    if (in_data.frame_start || RXW'(row_count) >= h) begin
      r = '0;
    end else begin
      r = RXW'(row_count);
    end
    lx   = (cfg.region_x == 10'd0) ? CXW'(1) : CXW'(cfg.region_x);
    rsum = CXW'(cfg.region_x) + CXW'(cfg.region_w);
    rx   = (rsum > w) ? w : rsum;
    tz   = (cfg.region_z == 12'd0) ? RXW'(1) : RXW'(cfg.region_z);
    bsum = RXW'(cfg.region_z) + RXW'(cfg.region_h);
    bz   = (bsum > h) ? h : bsum;
    qual = (c >= lx + CXW'(1)) && (c + CXW'(1) <= rx) &&
           (r >= tz + RXW'(1)) && (r + RXW'(1) <= bz);
    lastp = (c + CXW'(1) == rx) && (r + RXW'(1) == bz);
    if (c + CXW'(1) >= w) begin
      col_next = '0;
      row_next = (r + RXW'(1) >= h) ? '0 : RW'(r + RXW'(1));
    end else begin
      col_next = CW'(c + CXW'(1));
      row_next = RW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd0 <= lb0[c[AW-1:0]];
      rd1 <= lb1[c[AW-1:0]];
      if (r[0]) begin
        lb1[c[AW-1:0]] <= in_data.height;
      end else begin
        lb0[c[AW-1:0]] <= in_data.height;
      end
      a_par  <= r[0];
      a_h    <= in_data.height;
      a_q    <= qual;
      a_last <= lastp;
      a_col  <= 10'(c - CXW'(1));
      a_row  <= 12'(r - RXW'(1));
    end
    if (a_valid) begin
      b_col  <= a_col;
      b_row  <= a_row;
      b_last <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else begin
      a_valid <= accept;
      b_valid <= a_valid & a_q;
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
      if (a_valid) begin
        for (int i = 0; i < 3; i++) begin
          window[i*3]   <= window[i*3+1];
          window[i*3+1] <= window[i*3+2];
        end
        window[2] <= a_par ? rd1 : rd0;
        window[5] <= a_par ? rd0 : rd1;
        window[8] <= a_h;
      end
    end
  end

  assign q_push = b_valid;

  always_comb begin
    q_item.sx = 20'($signed({4'd0, window[0]})) + 20'($signed({3'd0, window[3], 1'b0}))
              + 20'($signed({4'd0, window[6]})) - 20'($signed({4'd0, window[2]}))
              - 20'($signed({3'd0, window[5], 1'b0})) - 20'($signed({4'd0, window[8]}));
    q_item.sz = 20'($signed({4'd0, window[0]})) + 20'($signed({3'd0, window[1], 1'b0}))
              + 20'($signed({4'd0, window[2]})) - 20'($signed({4'd0, window[6]}))
              - 20'($signed({3'd0, window[7], 1'b0})) - 20'($signed({4'd0, window[8]}));
    q_item.col  = b_col;
    q_item.row  = b_row;
    q_item.last = b_last;
  end

endmodule

>>> sv/hng_back.sv
module hng_back
  import hng_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  qitem_t q_item,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = F + 29;
  localparam int SQW = 58;
  localparam int RTW = SQW / 2;
  localparam int DRW = RTW + 1;
  localparam int BCW = $clog2(NW + 1);

  bstate_t state, state_next;

  qitem_t          cur;
  logic [37:0]     sq_x;
  logic [SQW-1:0]  sv;
  logic [RTW-1:0]  root;
  logic [RTW+2:0]  srem;
  logic [NW-1:0]   num, quo;
  logic [DRW-1:0]  drem;
  logic [1:0]      comp;
  logic [BCW-1:0]  bcnt;
  logic [15:0]     nx, ny, nz;

  logic            load_out;
  logic            root_done, div_done;
  logic [RTW+2:0]  s_shift, s_trial;
  logic [DRW-1:0]  d_shift;
  logic [17:0]     amag;
  logic            aneg;
  logic [18:0]     mag_x, mag_z;
  logic [NW-1:0]   qf, qc, qs;

  assign root_done = (bcnt == BCW'(RTW - 1));
  assign div_done  = (bcnt == BCW'(NW - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_SQ;
      B_SQ:   state_next = B_SUM;
      B_SUM:  state_next = B_ROOT;
      B_ROOT: if (root_done) state_next = B_DSET;
      B_DSET: state_next = B_DIV;
      B_DIV: begin
        if (div_done) state_next = (comp == 2'd2) ? B_OUT : B_DSET;
      end
      B_OUT:  if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == B_IDLE) && !q_empty;
    load_out = (state == B_OUT) && (!out_valid || !out_stall);
  end

  always_comb begin
    s_shift = {srem[RTW:0], sv[SQW-1:SQW-2]};
    s_trial = {1'b0, root, 2'b01};
    d_shift = {drem[DRW-2:0], num[NW-1]};
    mag_x = cur.sx[19] ? 19'(-cur.sx) : cur.sx[18:0];
    mag_z = cur.sz[19] ? 19'(-cur.sz) : cur.sz[18:0];
    case (comp)
      2'd0:    begin aneg = cur.sx[19]; amag = cur.sx[19] ? 18'(-cur.sx) : cur.sx[17:0]; end
      2'd1:    begin aneg = 1'b0; amag = 18'(SY); end
      default: begin aneg = cur.sz[19]; amag = cur.sz[19] ? 18'(-cur.sz) : cur.sz[17:0]; end
    endcase
    qf = {quo[NW-2:0], (d_shift >= DRW'(root))};
    qc = (qf > NW'(1) << F) ? NW'(1) << F : qf;
    qs = aneg ? (~qc + NW'(1)) : qc;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cur <= q_item;
      end
      B_SQ: begin
        sq_x <= 38'(mag_x) * 38'(mag_x);
      end
      B_SUM: begin
        sv   <= {sq_x + 38'(mag_z) * 38'(mag_z) + 38'(SY_SQ), 20'd0};
        srem <= '0;
        root <= '0;
        bcnt <= '0;
        comp <= '0;
      end
      B_ROOT: begin
        sv <= sv << 2;
        if (s_shift >= s_trial) begin
          srem <= s_shift - s_trial;
          root <= {root[RTW-2:0], 1'b1};
        end else begin
          srem <= s_shift;
          root <= {root[RTW-2:0], 1'b0};
        end
        bcnt <= bcnt + BCW'(1);
      end
      B_DSET: begin
        num  <= (NW'(amag) << (F + 10)) + NW'(root >> 1);
        drem <= '0;
        quo  <= '0;
        bcnt <= '0;
      end
      B_DIV: begin
        num <= num << 1;
        if (d_shift >= DRW'(root)) begin
          drem <= d_shift - DRW'(root);
          quo  <= {quo[NW-2:0], 1'b1};
        end else begin
          drem <= d_shift;
          quo  <= {quo[NW-2:0], 1'b0};
        end
        bcnt <= bcnt + BCW'(1);
        if (div_done) begin
          comp <= comp + 2'd1;
        end
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
    if (state == B_DIV && div_done) begin
      case (comp)
        2'd0:    nx <= qs[15:0];
        2'd1:    ny <= qs[15:0];
        default: nz <= qs[15:0];
      endcase
    end
    if (load_out) begin
      out_data.col      <= cur.col;
      out_data.row      <= cur.row;
      out_data.normal_x <= nx;
      out_data.normal_y <= ny;
      out_data.normal_z <= nz;
      out_data.last     <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
